[rtl/core/assert_macros.svh]
// Assertion macros for the RTL files; bmpsp_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/bmpsp_pkg.sv]
`default_nettype none

package bmpsp_pkg;

	localparam int MAX_DIM_DEF = 4096;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int POS_W = 32;
	localparam int XY_W = 12;

	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_HDR_SIZE = 3'd1;
	localparam logic [2:0] ERR_GEOMETRY = 3'd2;
	localparam logic [2:0] ERR_BPP = 3'd3;
	localparam logic [2:0] ERR_COMPRESSION = 3'd4;
	localparam logic [2:0] ERR_OFFSET = 3'd5;
	localparam logic [2:0] ERR_TRUNCATED = 3'd6;

	typedef struct packed {
		logic [7:0] data;
		logic end_mark;
		logic [POS_W-1:0] pos;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

endpackage

`default_nettype wire

[rtl/core/bmp24_stream_parser.sv]
// Results are registered: a byte passes the queue, then the output register.
// Throughput: one byte per cycle unless out_ready is low and stalls the output.
// A two-entry queue sits between the position tagger and the decoder.
// Reset (arst_n low) empties the queue and output and returns to header parsing.
// A stream_end transaction rearms the parser for the next file.
`default_nettype none

module bmp24_stream_parser #(
	parameter int MAX_DIM = bmpsp_pkg::MAX_DIM_DEF,
	parameter int QUEUE_DEPTH = bmpsp_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] in_byte,
	input wire logic stream_end,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [2:0] error_code,
	output logic [7:0] pixel_value,
	output logic [bmpsp_pkg::XY_W-1:0] x_pos,
	output logic [bmpsp_pkg::XY_W-1:0] y_pos,
	output logic [1:0] channel,
	output logic neg_height,
	output logic last
);

	bmpsp_pkg::item_t front_item;
	bmpsp_pkg::item_t back_item;
	logic push;
	logic full;
	logic pop;
	logic q_valid;

	bmpsp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.stream_end(stream_end),
		.full(full),
		.push(push),
		.item(front_item)
	);

	bmpsp_fifo #(
		.WIDTH(bmpsp_pkg::ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(front_item),
		.full(full),
		.pop(pop),
		.rd_valid(q_valid),
		.rd_data(back_item)
	);

	bmpsp_back #(
		.MAX_DIM(MAX_DIM)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(q_valid),
		.item(back_item),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.error_code(error_code),
		.pixel_value(pixel_value),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.channel(channel),
		.neg_height(neg_height),
		.last(last)
	);

endmodule

`default_nettype wire

[rtl/core/bmpsp_front.sv]
`default_nettype none

// Tags every accepted byte with its saturating position in the file.
module bmpsp_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] in_byte,
	input wire logic stream_end,
	input wire logic full,
	output logic push,
	output bmpsp_pkg::item_t item
);

	logic [bmpsp_pkg::POS_W-1:0] pos_q;

	assign in_ready = !full;
	assign push = in_valid && !full;

	always_comb begin
		item.data = in_byte;
		item.end_mark = stream_end;
		item.pos = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (stream_end) begin
				pos_q <= '0;
			end else if (pos_q != '1) begin
				pos_q <= pos_q + bmpsp_pkg::POS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/bmpsp_fifo.sv]
`default_nettype none

module bmpsp_fifo #(
	parameter int WIDTH = bmpsp_pkg::ITEM_W,
	parameter int DEPTH = bmpsp_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] wr_data,
	output logic full,
	input wire logic pop,
	output logic rd_valid,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/bmpsp_back.sv]
`default_nettype none
`include "assert_macros.svh"

// Header decoding, pixel walk and the output register.
module bmpsp_back #(
	parameter int MAX_DIM = bmpsp_pkg::MAX_DIM_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire bmpsp_pkg::item_t item,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [2:0] error_code,
	output logic [7:0] pixel_value,
	output logic [bmpsp_pkg::XY_W-1:0] x_pos,
	output logic [bmpsp_pkg::XY_W-1:0] y_pos,
	output logic [1:0] channel,
	output logic neg_height,
	output logic last
);

	localparam int DW = $clog2(MAX_DIM + 2);
	localparam logic [31:0] MAX32 = 32'(MAX_DIM);

	localparam logic [2:0] PH_HEAD = 3'd0;
	localparam logic [2:0] PH_SKIP = 3'd1;
	localparam logic [2:0] PH_PIXEL = 3'd2;
	localparam logic [2:0] PH_ROWPAD = 3'd3;
	localparam logic [2:0] PH_TAIL = 3'd4;
	localparam logic [2:0] PH_WAIT = 3'd5;

	localparam logic [31:0] POS_OFFSET = 32'd13;
	localparam logic [31:0] POS_INFO = 32'd17;
	localparam logic [31:0] POS_WIDTH = 32'd21;
	localparam logic [31:0] POS_HEIGHT = 32'd25;
	localparam logic [31:0] POS_PLANES = 32'd27;
	localparam logic [31:0] POS_BPP = 32'd29;
	localparam logic [31:0] POS_COMP = 32'd33;
	localparam logic [31:0] POS_CLR_USED = 32'd49;
	localparam logic [31:0] POS_CLR_IMP = 32'd53;

	logic [2:0] phase_q, n_phase;
	logic [31:0] shift_q, n_shift;
	logic [31:0] info_q, n_info;
	logic [DW-1:0] width_q, n_width;
	logic [DW-1:0] height_q, n_height;
	logic [15:0] planes_q, n_planes;
	logic [15:0] bpp_q, n_bpp;
	logic [31:0] comp_q, n_comp;
	logic [31:0] offset_q, n_offset;
	logic [1:0] ccs_q, n_ccs;
	logic [DW-1:0] col_q, n_col;
	logic [DW-1:0] row_q, n_row;
	logic [1:0] chan_q, n_chan;
	logic [1:0] pad_q, n_pad;
	logic flip_q, n_flip;

	logic res_valid;
	logic [1:0] res_kind;
	logic [2:0] res_err;
	logic res_last;
	logic do_pixel;
	logic [2:0] hdr_err;
	logic [31:0] v;
	logic [31:0] neg_v;
	logic [1:0] pad_dec;
	logic [DW-1:0] col_inc;
	logic [DW-1:0] row_inc;
	logic last_col;
	logic last_row;

	logic out_valid_q;
	logic [1:0] kind_q;
	logic [2:0] err_q;
	logic [7:0] pix_q;
	logic [bmpsp_pkg::XY_W-1:0] x_q;
	logic [bmpsp_pkg::XY_W-1:0] y_q;
	logic [1:0] chan_out_q;
	logic flip_out_q;
	logic last_q;

	function automatic logic [DW-1:0] clamp_dim(input logic [31:0] mag);
		return (mag > MAX32) ? DW'(MAX_DIM + 1) : DW'(mag);
	endfunction

	assign pop = item_valid && (!out_valid_q || out_ready);
	assign v = {item.data, shift_q[31:8]};
	assign neg_v = ~v + 32'd1;
	assign pad_dec = pad_q - 2'd1;
	assign col_inc = col_q + DW'(1);
	assign row_inc = row_q + DW'(1);
	assign last_col = !(col_inc < width_q);
	assign last_row = row_inc >= height_q;

	always_comb begin
		n_phase = phase_q;
		n_shift = shift_q;
		n_info = info_q;
		n_width = width_q;
		n_height = height_q;
		n_planes = planes_q;
		n_bpp = bpp_q;
		n_comp = comp_q;
		n_offset = offset_q;
		n_ccs = ccs_q;
		n_col = col_q;
		n_row = row_q;
		n_chan = chan_q;
		n_pad = pad_q;
		n_flip = flip_q;
		res_valid = 1'b0;
		res_kind = bmpsp_pkg::KIND_PIXEL;
		res_err = bmpsp_pkg::ERR_NONE;
		res_last = 1'b0;
		do_pixel = 1'b0;
		hdr_err = bmpsp_pkg::ERR_NONE;

		if (item.end_mark) begin
			n_phase = PH_HEAD;
			n_shift = '0;
			n_info = '0;
			n_width = '0;
			n_height = '0;
			n_planes = '0;
			n_bpp = '0;
			n_comp = '0;
			n_offset = '0;
			n_ccs = '0;
			n_col = '0;
			n_row = '0;
			n_chan = '0;
			n_pad = '0;
			n_flip = 1'b0;
			if (phase_q == PH_TAIL && pad_q == 2'd0) begin
				res_valid = 1'b1;
				res_kind = bmpsp_pkg::KIND_DONE;
			end else if (phase_q != PH_WAIT) begin
				res_valid = 1'b1;
				res_kind = bmpsp_pkg::KIND_ERROR;
				res_err = bmpsp_pkg::ERR_TRUNCATED;
			end
		end else begin
			unique case (phase_q)
				PH_HEAD: begin
					n_shift = v;
					unique case (item.pos)
						POS_OFFSET: n_offset = v;
						POS_INFO: begin
							n_info = v;
							if (v != 32'd40 && v != 32'd108 && v != 32'd124) begin
								hdr_err = bmpsp_pkg::ERR_HDR_SIZE;
							end
						end
						POS_WIDTH: n_width = v[31] ? '0 : clamp_dim(v);
						POS_HEIGHT: begin
							n_flip = v[31];
							n_height = v[31] ? clamp_dim(neg_v) : clamp_dim(v);
						end
						POS_PLANES: n_planes = v[31:16];
						POS_BPP: n_bpp = v[31:16];
						POS_COMP: n_comp = v;
						POS_CLR_USED: n_ccs = {ccs_q[1], v[31]};
						POS_CLR_IMP: begin
							n_ccs = {v[31], ccs_q[0]};
							priority if (width_q == '0 || height_q == '0 || planes_q == '0 ||
									planes_q[15] || bpp_q == '0 || bpp_q[15] ||
									n_ccs != 2'd0) begin
								hdr_err = bmpsp_pkg::ERR_GEOMETRY;
							end else if (width_q > DW'(MAX_DIM) || height_q > DW'(MAX_DIM)) begin
								hdr_err = bmpsp_pkg::ERR_TRUNCATED;
							end else if (bpp_q != 16'd24) begin
								hdr_err = bmpsp_pkg::ERR_BPP;
							end else if (comp_q != '0) begin
								hdr_err = bmpsp_pkg::ERR_COMPRESSION;
							end else if ({1'b0, offset_q} < 33'd14 + {1'b0, info_q}) begin
								hdr_err = bmpsp_pkg::ERR_OFFSET;
							end else begin
								hdr_err = bmpsp_pkg::ERR_NONE;
							end
						end
						default: ;
					endcase
					if (hdr_err != bmpsp_pkg::ERR_NONE) begin
						n_phase = PH_WAIT;
						res_valid = 1'b1;
						res_kind = bmpsp_pkg::KIND_ERROR;
						res_err = hdr_err;
					end else if (item.pos == POS_CLR_IMP) begin
						n_phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (item.pos >= offset_q) begin
						n_phase = PH_PIXEL;
						do_pixel = 1'b1;
					end
				end
				PH_PIXEL: do_pixel = 1'b1;
				PH_ROWPAD: begin
					n_pad = pad_dec;
					if (pad_dec == 2'd0) begin
						n_phase = PH_PIXEL;
					end
				end
				PH_TAIL: begin
					if (pad_q != 2'd0) begin
						n_pad = pad_dec;
					end
					if (pad_q == 2'd0 || pad_dec == 2'd0) begin
						n_phase = PH_WAIT;
						res_valid = 1'b1;
						res_kind = bmpsp_pkg::KIND_DONE;
					end
				end
				default: ;
			endcase

			if (do_pixel) begin
				res_valid = 1'b1;
				res_kind = bmpsp_pkg::KIND_PIXEL;
				res_last = (chan_q == 2'd2) && last_col && last_row;
				if (chan_q != 2'd2) begin
					n_chan = chan_q + 2'd1;
				end else begin
					n_chan = 2'd0;
					if (!last_col) begin
						n_col = col_inc;
					end else begin
						n_col = '0;
						n_pad = width_q[1:0];
						if (last_row) begin
							n_phase = PH_TAIL;
						end else begin
							n_row = row_inc;
							if (width_q[1:0] != 2'd0) begin
								n_phase = PH_ROWPAD;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			shift_q <= '0;
			info_q <= '0;
			width_q <= '0;
			height_q <= '0;
			planes_q <= '0;
			bpp_q <= '0;
			comp_q <= '0;
			offset_q <= '0;
			ccs_q <= '0;
			col_q <= '0;
			row_q <= '0;
			chan_q <= '0;
			pad_q <= '0;
			flip_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= n_phase;
				shift_q <= n_shift;
				info_q <= n_info;
				width_q <= n_width;
				height_q <= n_height;
				planes_q <= n_planes;
				bpp_q <= n_bpp;
				comp_q <= n_comp;
				offset_q <= n_offset;
				ccs_q <= n_ccs;
				col_q <= n_col;
				row_q <= n_row;
				chan_q <= n_chan;
				pad_q <= n_pad;
				flip_q <= n_flip;
				out_valid_q <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			kind_q <= res_kind;
			err_q <= res_err;
			if (res_kind == bmpsp_pkg::KIND_PIXEL) begin
				pix_q <= item.data;
				x_q <= bmpsp_pkg::XY_W'(col_q);
				y_q <= bmpsp_pkg::XY_W'(row_q);
				chan_out_q <= chan_q;
				flip_out_q <= flip_q;
				last_q <= res_last;
			end else begin
				pix_q <= '0;
				x_q <= '0;
				y_q <= '0;
				chan_out_q <= '0;
				flip_out_q <= 1'b0;
				last_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign error_code = err_q;
	assign pixel_value = pix_q;
	assign x_pos = x_q;
	assign y_pos = y_q;
	assign channel = chan_out_q;
	assign neg_height = flip_out_q;
	assign last = last_q;

	`ASSERT_IMPLIES(a_pad_phase, pad_q != 2'd0, phase_q == PH_ROWPAD || phase_q == PH_TAIL, "padding left outside a padding phase")
	`ASSERT_IMPLIES(a_chan_range, phase_q == PH_PIXEL, chan_q != 2'd3, "channel counter out of range")
	`ASSERT_IMPLIES(a_col_bound, phase_q == PH_PIXEL, col_q < width_q, "column beyond image width")
	`ASSERT_NEXT(a_last_tail, pop && res_last, phase_q == PH_TAIL, "no tail phase after the last pixel")
	`ASSERT_IMPLIES(a_pixel_code, out_valid_q && kind_q == bmpsp_pkg::KIND_PIXEL, err_q == bmpsp_pkg::ERR_NONE, "pixel transaction carries an error code")

endmodule

`default_nettype wire

[verif/bmp_result_checker.sv]
module bmp_result_checker
	import bmpsp_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [7:0] in_byte,
	input wire logic stream_end,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [1:0] kind,
	input wire logic [2:0] error_code,
	input wire logic [7:0] pixel_value,
	input wire logic [XY_W-1:0] x_pos,
	input wire logic [XY_W-1:0] y_pos,
	input wire logic [1:0] channel,
	input wire logic neg_height,
	input wire logic last,
	output int fail_count,
	output int pending,
	output int pixel_count,
	output int done_count,
	output int error_count,
	output logic [7:0] codes_seen
);

	typedef enum logic [2:0] {
		ST_HEAD, ST_SKIP, ST_PIXEL, ST_ROWPAD, ST_TAIL, ST_WAIT
	} parse_phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] code;
		logic [7:0] value;
		logic [XY_W-1:0] x;
		logic [XY_W-1:0] y;
		logic [1:0] chan;
		logic top;
		logic last;
	} pix_result_t;

	parse_phase_t ph;
	logic [31:0] pos_cnt, shift_reg, hdr_size, width_mag, height_mag, compr, pix_offset;
	logic [15:0] planes, bpp;
	logic [1:0] neg_colors;
	logic [31:0] col, row;
	logic [1:0] chan, pad_left;
	logic flip;

	pix_result_t expected_q[$];

	task automatic clear_state();
		ph = ST_HEAD;
		pos_cnt = '0;
		shift_reg = '0;
		hdr_size = '0;
		width_mag = '0;
		height_mag = '0;
		compr = '0;
		pix_offset = '0;
		planes = '0;
		bpp = '0;
		neg_colors = '0;
		col = '0;
		row = '0;
		chan = '0;
		pad_left = '0;
		flip = 1'b0;
	endtask

	function automatic logic [31:0] clamp_dim(input logic [31:0] m);
		return (m > 32'(MAX_DIM)) ? 32'(MAX_DIM) + 32'd1 : m;
	endfunction

	function automatic logic [2:0] header_verdict();
		if (width_mag == 0 || height_mag == 0 || planes == 0 || planes[15] ||
		    bpp == 0 || bpp[15] || neg_colors != 0)
			return ERR_GEOMETRY;
		if (width_mag > 32'(MAX_DIM) || height_mag > 32'(MAX_DIM))
			return ERR_TRUNCATED;
		if (bpp != 16'd24)
			return ERR_BPP;
		if (compr != 0)
			return ERR_COMPRESSION;
		if ({32'd0, pix_offset} < 64'd14 + {32'd0, hdr_size})
			return ERR_OFFSET;
		return ERR_NONE;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic e, output logic got,
			output pix_result_t r);
		parse_phase_t was_ph;
		logic [1:0] was_pad;
		logic [31:0] at, v, t;
		logic [2:0] code;
		logic fin;
		r = '0;
		got = 1'b0;
		code = ERR_NONE;
		if (e) begin
			was_ph = ph;
			was_pad = pad_left;
			clear_state();
			if (was_ph == ST_TAIL && was_pad == 0) begin
				got = 1'b1;
				r.kind = KIND_DONE;
			end else if (was_ph != ST_WAIT) begin
				got = 1'b1;
				r.kind = KIND_ERROR;
				r.code = ERR_TRUNCATED;
			end
			return;
		end
		at = pos_cnt;
		if (pos_cnt != 32'hFFFF_FFFF)
			pos_cnt = pos_cnt + 32'd1;
		case (ph)
			ST_HEAD: begin
				shift_reg = {b, shift_reg[31:8]};
				v = shift_reg;
				case (at)
					13: pix_offset = v;
					17: begin
						hdr_size = v;
						if (v != 40 && v != 108 && v != 124)
							code = ERR_HDR_SIZE;
					end
					21: width_mag = v[31] ? 32'd0 : clamp_dim(v);
					25: begin
						flip = v[31];
						height_mag = clamp_dim(v[31] ? (~v) + 32'd1 : v);
					end
					27: planes = v[31:16];
					29: bpp = v[31:16];
					33: compr = v;
					49: neg_colors[0] = v[31];
					53: begin
						neg_colors[1] = v[31];
						code = header_verdict();
					end
					default: ;
				endcase
				if (code != ERR_NONE) begin
					ph = ST_WAIT;
					got = 1'b1;
					r.kind = KIND_ERROR;
					r.code = code;
				end else if (at == 53) begin
					ph = ST_SKIP;
				end
				return;
			end
			ST_SKIP: begin
				if (at < pix_offset)
					return;
				ph = ST_PIXEL;
			end
			ST_ROWPAD: begin
				pad_left = pad_left - 2'd1;
				if (pad_left == 0)
					ph = ST_PIXEL;
				return;
			end
			ST_TAIL: begin
				if (pad_left != 0) begin
					pad_left = pad_left - 2'd1;
					if (pad_left != 0)
						return;
				end
				ph = ST_WAIT;
				got = 1'b1;
				r.kind = KIND_DONE;
				return;
			end
			ST_PIXEL: ;
			default: return;
		endcase

		fin = (chan == 2'd2) && (col + 32'd1 >= width_mag) && (row + 32'd1 >= height_mag);
		got = 1'b1;
		r.kind = KIND_PIXEL;
		r.value = b;
		r.x = col[XY_W-1:0];
		r.y = row[XY_W-1:0];
		r.chan = chan;
		r.top = flip;
		r.last = fin;
		if (chan < 2'd2) begin
			chan = chan + 2'd1;
		end else begin
			chan = '0;
			if (col + 32'd1 < width_mag) begin
				col = col + 32'd1;
			end else begin
				col = '0;
				t = 32'd4 - ((width_mag * 32'd3) & 32'd3);
				pad_left = t[1:0];
				if (row + 32'd1 >= height_mag) begin
					ph = ST_TAIL;
				end else begin
					row = row + 32'd1;
					if (pad_left != 0)
						ph = ST_ROWPAD;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pix_result_t want, seen;
		logic got;
		if (!arst_n) begin
			clear_state();
			expected_q.delete();
			fail_count = 0;
			pixel_count = 0;
			done_count = 0;
			error_count = 0;
			codes_seen = '0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {kind, error_code, pixel_value, x_pos, y_pos, channel, neg_height, last};
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, actual kind=%0d err=%0d",
						$time, kind, error_code);
				end else begin
					want = expected_q.pop_front();
					if (want != seen) begin
						fail_count++;
						$display({"%0t: result mismatch: expected kind=%0d err=%0d value=%0d ",
							"x=%0d y=%0d ch=%0d neg_height=%0d last=%0d, actual kind=%0d ",
							"err=%0d value=%0d x=%0d y=%0d ch=%0d neg_height=%0d last=%0d"},
							$time, want.kind, want.code, want.value, want.x, want.y,
							want.chan, want.top, want.last, seen.kind, seen.code,
							seen.value, seen.x, seen.y, seen.chan, seen.top, seen.last);
					end
					case (want.kind)
						KIND_PIXEL: pixel_count++;
						KIND_DONE: done_count++;
						default: begin
							error_count++;
							codes_seen[want.code] = 1'b1;
						end
					endcase
				end
			end
			if (in_valid && in_ready) begin
				decode_byte(in_byte, stream_end, got, want);
				if (got)
					expected_q.push_back(want);
			end
		end
		pending = expected_q.size();
	end

endmodule

[verif/tb_top.sv]
module tb_top;
	import bmpsp_pkg::*;

	localparam int MAX_SIDE = MAX_DIM_DEF;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 300;

	typedef struct {
		logic [31:0] offset, hdr, width, height, compr, used, important;
		logic [15:0] planes, bpp;
		int cut, tail;
	} bmp_plan_t;

	logic clk = 1'b0;
	logic arst_n, in_valid, in_ready, stream_end, out_valid, out_ready, neg_height, last;
	logic [7:0] in_byte, pixel_value;
	logic [1:0] kind, channel;
	logic [2:0] error_code;
	logic [XY_W-1:0] x_pos, y_pos;
	int fail_count, pending, pixel_count, done_count, error_count;
	logic [7:0] codes_seen;
	int sent_count = 0;
	int file_count = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	logic [7:0] file_bytes[$];

	always #4 clk = ~clk;

	bmp24_stream_parser DUT (
		.clk, .arst_n, .in_valid, .in_ready, .in_byte, .stream_end,
		.out_valid, .out_ready, .kind, .error_code, .pixel_value,
		.x_pos, .y_pos, .channel, .neg_height, .last
	);

	bmp_result_checker u_checker (
		.clk, .arst_n, .in_valid, .in_ready, .in_byte, .stream_end,
		.out_valid, .out_ready, .kind, .error_code, .pixel_value,
		.x_pos, .y_pos, .channel, .neg_height, .last,
		.fail_count, .pending, .pixel_count, .done_count, .error_count, .codes_seen
	);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: watchdog: no transaction for %0d cycles, %0d results pending",
				$time, WATCHDOG_LIMIT, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : receiver
		int stall, run, mode;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			mode = $urandom_range(0, 9);
			if (mode < 2) begin
				stall = 0;
				run = $urandom_range(100, 300);
			end else if (mode < 4) begin
				stall = $urandom_range(5, 40);
				run = $urandom_range(1, 4);
			end else begin
				stall = $urandom_range(0, 3);
				run = $urandom_range(1, 8);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat (run) @(negedge clk);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic e);
		in_byte <= b;
		stream_end <= e;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_paced(input logic [7:0] b, input logic e);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 4) == 0) begin
				gap = 0;
				burst_left = $urandom_range(100, 400);
			end else begin
				gap = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 6);
				burst_left = $urandom_range(1, 16);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		send_item(b, e);
		burst_left--;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(v[8*i +: 8]);
	endtask

	task automatic put_rand(input int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(8'($urandom));
	endtask

	function automatic bmp_plan_t plain_plan(input logic [31:0] w, input logic [31:0] h);
		bmp_plan_t p;
		p.offset = 32'd54;
		p.hdr = 32'd40;
		p.width = w;
		p.height = h;
		p.compr = '0;
		p.used = '0;
		p.important = '0;
		p.planes = 16'd1;
		p.bpp = 16'd24;
		p.cut = -1;
		p.tail = 0;
		return p;
	endfunction

	function automatic bmp_plan_t random_good_plan();
		bmp_plan_t p;
		logic [31:0] w, h;
		w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
		h = $urandom_range(1, 4);
		if ($urandom_range(0, 2) == 0)
			h = -h;
		p = plain_plan(w, h);
		case ($urandom_range(0, 2))
			0: p.hdr = 32'd40;
			1: p.hdr = 32'd108;
			default: p.hdr = 32'd124;
		endcase
		p.offset = 32'd14 + p.hdr + $urandom_range(0, 5);
		if ($urandom_range(0, 2) == 0)
			p.planes = 16'($urandom_range(1, 16'h7FFF));
		if ($urandom_range(0, 2) == 0)
			p.used = $urandom & 32'h7FFF_FFFF;
		if ($urandom_range(0, 2) == 0)
			p.important = $urandom & 32'h7FFF_FFFF;
		if ($urandom_range(0, 1) == 0)
			p.tail = $urandom_range(0, 3);
		return p;
	endfunction

	task automatic run_file(input bmp_plan_t p);
		logic [31:0] hm, total, gap;
		file_bytes.delete();
		put_le($urandom_range(0, 1) ? 32'h4D42 : $urandom, 2);
		put_le($urandom, 4);
		put_le($urandom_range(0, 1) ? 32'd0 : $urandom, 4);
		put_le(p.offset, 4);
		put_le(p.hdr, 4);
		put_le(p.width, 4);
		put_le(p.height, 4);
		put_le(32'(p.planes), 2);
		put_le(32'(p.bpp), 2);
		put_le(p.compr, 4);
		put_le($urandom, 4);
		put_le($urandom, 4);
		put_le($urandom, 4);
		put_le(p.used, 4);
		put_le(p.important, 4);
		gap = (p.offset > 32'd54) ? p.offset - 32'd54 : 32'd0;
		if (gap > 32'd128)
			gap = 32'd128;
		put_rand(gap);
		hm = p.height[31] ? (~p.height) + 32'd1 : p.height;
		if (p.width >= 1 && p.width <= MAX_SIDE && hm >= 1 && hm <= MAX_SIDE)
			total = hm * ((p.width * 32'd3 + 32'd3) & ~32'd3);
		else
			total = 32'd8;
		put_rand(total + p.tail);
		if (p.cut >= 0)
			while (file_bytes.size() > p.cut)
				void'(file_bytes.pop_back());
		foreach (file_bytes[i])
			send_paced(file_bytes[i], 1'b0);
		send_paced(8'($urandom), 1'b1);
		file_count++;
	endtask

	task automatic run_noise(input int n);
		for (int i = 0; i < n; i++)
			send_paced(8'($urandom), ($urandom_range(0, 19) == 0));
		send_paced(8'($urandom), 1'b1);
		file_count++;
	endtask

	initial begin : stimulus
		bmp_plan_t p;
		int directed_sent, pick;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= '0;
		stream_end <= 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty file right after reset, then small images of every padding size.
		send_paced(8'hFF, 1'b1);
		run_file(plain_plan(1, 1));
		run_file(plain_plan(2, 2));
		p = plain_plan(3, -2);
		p.hdr = 108;
		p.offset = 14 + 108 + 3;
		run_file(p);
		p = plain_plan(4, 1);
		p.tail = 1;
		run_file(p);
		run_file(plain_plan(4, 2));
		send_paced(8'h00, 1'b1);
		p = plain_plan(5, 3);
		p.hdr = 124;
		p.offset = 138;
		p.planes = 16'h7FFF;
		p.used = 32'h7FFF_FFFF;
		p.important = 32'h7FFF_FFFF;
		run_file(p);

		// Header rejections.
		p = plain_plan(2, 2);
		p.hdr = 41;
		run_file(p);
		p.hdr = 32'hFFFF_FFFF;
		run_file(p);
		run_file(plain_plan(0, 2));
		run_file(plain_plan(32'h8000_0000, 2));
		run_file(plain_plan(2, 0));
		p = plain_plan(2, 2);
		p.planes = 16'd0;
		run_file(p);
		p.planes = 16'h8000;
		run_file(p);
		p = plain_plan(2, 2);
		p.bpp = 16'hFFFF;
		run_file(p);
		p = plain_plan(2, 2);
		p.used = 32'h8000_0000;
		run_file(p);
		p = plain_plan(2, 2);
		p.important = 32'hFFFF_FFFF;
		run_file(p);
		run_file(plain_plan(MAX_SIDE + 1, 1));
		run_file(plain_plan(1, 32'h8000_0000));
		p = plain_plan(2, 2);
		p.bpp = 16'd32;
		run_file(p);
		p = plain_plan(2, 2);
		p.compr = 32'hFFFF_FFFF;
		run_file(p);
		p = plain_plan(2, 2);
		p.offset = 53;
		run_file(p);

		// Truncation: huge offset, inside the header, inside row and final padding.
		p = plain_plan(2, 2);
		p.offset = 32'hFFFF_FFFF;
		p.cut = 80;
		run_file(p);
		p = plain_plan(2, 2);
		p.cut = 30;
		run_file(p);
		p = plain_plan(1, 2);
		p.cut = 57;
		run_file(p);
		p = plain_plan(2, 1);
		p.cut = 61;
		run_file(p);

		// Largest geometry, each side once, cut short after the first pixels.
		p = plain_plan(MAX_SIDE, 1);
		p.cut = 80;
		run_file(p);
		p = plain_plan(1, -MAX_SIDE);
		p.cut = 80;
		run_file(p);
		drain();
		directed_sent = sent_count;

		while (sent_count - directed_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			p = random_good_plan();
			if (pick >= 60 && pick < 66) begin
				p.cut = $urandom_range(0, 54 + p.width * 12);
			end else if (pick >= 66 && pick < 88) begin
				p.cut = 54 + $urandom_range(0, 10);
				case ($urandom_range(0, 9))
					0: p.hdr = ($urandom_range(0, 1) == 0) ? $urandom : p.hdr + 1;
					1: p.width = ($urandom_range(0, 1) == 0) ? $urandom : 0;
					2: p.height = ($urandom_range(0, 1) == 0) ? $urandom : 0;
					3: p.planes = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
					4: p.bpp = 16'($urandom);
					5: p.compr = $urandom_range(1, 3);
					6: p.used = $urandom | 32'h8000_0000;
					7: p.important = $urandom | 32'h8000_0000;
					8: p.offset = $urandom_range(0, 13 + p.hdr);
					default: p.width = $urandom_range(MAX_SIDE + 1, 32'h7FFF_FFFF);
				endcase
			end
			if (pick >= 88 && pick < 96)
				run_noise($urandom_range(1, 80));
			else
				run_file(p);
			if ($urandom_range(0, 9) == 0)
				drain();
		end

		drain();
		repeat (16) @(negedge clk);
		$display("summary: %0d input transactions in %0d files; %0d pixel bytes,",
			sent_count, file_count, pixel_count);
		$display("summary: %0d images, %0d errors, error codes returned (bit per code): %b",
			done_count, error_count, codes_seen);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
